// ===== rtl/core/gts_pkg.sv =====
// Shared types, constants and codes for the guarded transition selector.
package gts_pkg;

  localparam int NUM_SENSORS_DEF          = 16;
  localparam int NUM_TRANSITIONS_DEF      = 16;
  localparam int CONDS_PER_TRANSITION_DEF = 4;

  localparam int VALUE_W   = 16;
  localparam int STATE_W   = 4;
  localparam int ENTRY_W   = 4;
  localparam int SLOT_W    = 2;
  localparam int SEL_W     = 5;
  localparam int CNT_W     = 5;
  localparam int CCOUNT_W  = 3;
  localparam int TOL_W     = 15;
  localparam int DRAW_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SENSORS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITIONS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQUAL_TOLERANCE    = 2'd2;

  localparam logic [CNT_W-1:0] SENSORS_RESET     = 5'd16;
  localparam logic [CNT_W-1:0] TRANSITIONS_RESET = 5'd0;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET   = 15'd20;

  typedef enum logic [1:0] {
    OP_WRITE_SENSOR = 2'd0,
    OP_WRITE_HEADER = 2'd1,
    OP_WRITE_COND   = 2'd2,
    OP_STEP         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMP_EQUAL   = 2'd0,
    CMP_GREATER = 2'd1,
    CMP_LESS    = 2'd2,
    CMP_INVALID = 2'd3
  } cmp_t;

  // Input transaction payload.
  typedef struct packed {
    op_t                       operation;
    logic [ENTRY_W-1:0]        entry_index;
    logic [SLOT_W-1:0]         slot_index;
    logic signed [VALUE_W-1:0] sample_value;
    logic [SEL_W-1:0]          sensor_select;
    cmp_t                      compare_op;
    logic [STATE_W-1:0]        from_state;
    logic [STATE_W-1:0]        to_state;
    logic                      enabled;
    logic                      use_or;
    logic [CCOUNT_W-1:0]       condition_count;
    logic [DRAW_W-1:0]         random_draw;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [STATE_W-1:0] new_state;
    logic [CNT_W-1:0]   eligible_count;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic write_sensor;
    logic write_header;
    logic write_cond;
    logic step_start;  // latch draw, clear counters, index 0
    logic trans_load;  // header read data valid: start guard
    logic cond_eval;   // condition read data valid: fold in
    logic trans_done;  // close guard of current transition
    logic trans_next;  // advance transition index
    logic pass2;       // switch to selection pass
    logic mod_start;
    logic mod_step;
    logic finish;      // commit state
  } cmd_t;

  typedef struct packed {
    logic trans_last;   // current index is the last in use
    logic no_trans;     // nothing in use
    logic cond_last;    // current condition is the last of the transition
    logic cond_none;    // transition has no conditions or wrong begin state
    logic picked;       // selection pass found its target
    logic mod_done;
    logic any_eligible;
  } status_t;

endpackage

// ===== rtl/core/gts_if.sv =====
// Valid/ready channel interface carrying a payload struct.
interface gts_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gts_ram.sv =====
// Generic single-port write, single-port read RAM with registered read.
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/gts_datapath.sv =====
// Datapath: sensor registers, header and condition RAMs, guard evaluation, modulo.
module gts_datapath #(
  parameter int NUM_SENSORS          = gts_pkg::NUM_SENSORS_DEF,
  parameter int NUM_TRANSITIONS      = gts_pkg::NUM_TRANSITIONS_DEF,
  parameter int CONDS_PER_TRANSITION = gts_pkg::CONDS_PER_TRANSITION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gts_pkg::cmd_t                 cmd,
  output gts_pkg::status_t              status,
  input  logic [gts_pkg::ENTRY_W-1:0]   in_entry,
  input  logic [gts_pkg::SLOT_W-1:0]    in_slot,
  input  logic [gts_pkg::VALUE_W-1:0]   in_value,
  input  logic [gts_pkg::SEL_W-1:0]     in_sel,
  input  logic [1:0]                    in_cmp,
  input  logic [gts_pkg::STATE_W-1:0]   in_from,
  input  logic [gts_pkg::STATE_W-1:0]   in_to,
  input  logic                          in_enabled,
  input  logic                          in_use_or,
  input  logic [gts_pkg::CCOUNT_W-1:0]  in_ccount,
  input  logic [gts_pkg::DRAW_W-1:0]    in_draw,
  input  logic [gts_pkg::CNT_W-1:0]     sensors_in_use,
  input  logic [gts_pkg::CNT_W-1:0]     transitions_in_use,
  input  logic [gts_pkg::TOL_W-1:0]     equal_tolerance,
  output logic [gts_pkg::STATE_W-1:0]   new_state,
  output logic [gts_pkg::CNT_W-1:0]     eligible_count
);
  localparam int TI_W   = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
  localparam int TC_W   = $clog2(NUM_TRANSITIONS + 1);
  localparam int CI_W   = (CONDS_PER_TRANSITION > 1) ? $clog2(CONDS_PER_TRANSITION) : 1;
  localparam int CC_W   = $clog2(CONDS_PER_TRANSITION + 1);
  localparam int SI_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SLOTS  = NUM_TRANSITIONS * CONDS_PER_TRANSITION;
  localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HDR_W  = 2 * gts_pkg::STATE_W + 2 + gts_pkg::CCOUNT_W;
  localparam int CND_W  = gts_pkg::SEL_W + 2 + gts_pkg::VALUE_W;
  localparam int DW     = gts_pkg::DRAW_W;

  logic signed [gts_pkg::VALUE_W-1:0] sensors [NUM_SENSORS];

  logic [gts_pkg::STATE_W-1:0] cur_state;
  logic [TI_W-1:0]             tr_idx;
  logic [CI_W-1:0]             c_idx;
  logic [TC_W-1:0]             count;
  logic [TC_W-1:0]             seen;
  logic                        any_c, all_c, sel_pass;
  logic [NUM_TRANSITIONS-1:0]  elig;
  logic [gts_pkg::STATE_W-1:0] chosen;
  logic                        chosen_set;

  // restoring modulo
  logic [DW-1:0]   rem;
  logic [DW-1:0]   quo_bits;
  logic [$clog2(DW+1)-1:0] mod_cnt;

  logic [HDR_W-1:0] hdr_rd;
  logic [CND_W-1:0] cnd_rd;
  logic [TI_W-1:0]  hdr_raddr;
  logic [SA_W-1:0]  cnd_raddr;

  logic hdr_we, cnd_we;
  logic [TI_W-1:0] in_tr;
  logic [CI_W-1:0] in_sl;
  logic [SA_W-1:0] cnd_waddr;
  assign in_tr = TI_W'(in_entry);
  assign in_sl = CI_W'(in_slot);
  assign hdr_we = cmd.write_header && (32'(in_entry) < NUM_TRANSITIONS);
  assign cnd_we = cmd.write_cond && (32'(in_entry) < NUM_TRANSITIONS) &&
                  (32'(in_slot) < CONDS_PER_TRANSITION);
  assign cnd_waddr = SA_W'(32'(in_tr) * CONDS_PER_TRANSITION + 32'(in_sl));

  gts_ram #(.WIDTH(HDR_W), .DEPTH(NUM_TRANSITIONS)) u_hdr (
    .clk(clk), .we(hdr_we), .waddr(in_tr),
    .wdata({in_from, in_to, in_enabled, in_use_or, in_ccount}),
    .raddr(hdr_raddr), .rdata(hdr_rd)
  );
  gts_ram #(.WIDTH(CND_W), .DEPTH(SLOTS)) u_cnd (
    .clk(clk), .we(cnd_we), .waddr(cnd_waddr),
    .wdata({in_sel, in_cmp, in_value}),
    .raddr(cnd_raddr), .rdata(cnd_rd)
  );

  // header fields
  logic [gts_pkg::STATE_W-1:0]  h_from, h_to;
  logic                         h_en, h_or;
  logic [gts_pkg::CCOUNT_W-1:0] h_cnt;
  assign {h_from, h_to, h_en, h_or, h_cnt} = hdr_rd;
  logic [gts_pkg::STATE_W-1:0]  t_to;
  logic                         t_en, t_or;
  logic [CC_W-1:0]              t_cnt;

  logic [CC_W-1:0] h_cnt_clip;
  always_comb begin
    if (32'(h_cnt) > CONDS_PER_TRANSITION) h_cnt_clip = CC_W'(CONDS_PER_TRANSITION);
    else h_cnt_clip = CC_W'(h_cnt);
  end

  // condition path
  logic [gts_pkg::SEL_W-1:0]          c_sel;
  logic [1:0]                         c_op;
  logic signed [gts_pkg::VALUE_W-1:0] c_thr;
  assign {c_sel, c_op, c_thr} = cnd_rd;
  logic signed [gts_pkg::VALUE_W-1:0] s_val;
  logic signed [gts_pkg::VALUE_W:0]   diff;
  logic [gts_pkg::VALUE_W:0]          adiff;
  logic                               c_true, s_ok;
  always_comb begin
    s_ok  = (c_sel < sensors_in_use) && (32'(c_sel) < NUM_SENSORS);
    s_val = sensors[SI_W'(c_sel)];
    diff  = {s_val[gts_pkg::VALUE_W-1], s_val} - {c_thr[gts_pkg::VALUE_W-1], c_thr};
    adiff = diff[gts_pkg::VALUE_W] ? (gts_pkg::VALUE_W+1)'(-diff) : diff;
    case (gts_pkg::cmp_t'(c_op))
      gts_pkg::CMP_EQUAL:   c_true = adiff < (gts_pkg::VALUE_W+1)'(equal_tolerance);
      gts_pkg::CMP_GREATER: c_true = s_val > c_thr;
      gts_pkg::CMP_LESS:    c_true = s_val < c_thr;
      default:              c_true = 1'b0;
    endcase
    c_true = c_true && s_ok;
  end

  logic [TC_W-1:0] limit;
  always_comb begin
    if (32'(transitions_in_use) > NUM_TRANSITIONS) limit = TC_W'(NUM_TRANSITIONS);
    else limit = TC_W'(transitions_in_use);
  end

  // the condition read runs one slot ahead of the slot being folded in
  assign hdr_raddr = tr_idx;
  assign cnd_raddr = SA_W'(32'(tr_idx) * CONDS_PER_TRANSITION + 32'(c_idx) +
                           (cmd.cond_eval ? 32'd1 : 32'd0));

  logic begin_match;
  assign begin_match = (h_from == cur_state);

  logic guard;
  assign guard = (t_or ? any_c : all_c) && t_en;

  always_comb begin
    status.trans_last   = (32'(tr_idx) + 1 >= 32'(limit));
    status.no_trans     = (limit == '0);
    status.cond_last    = (32'(c_idx) + 1 >= 32'(t_cnt));
    status.cond_none    = !begin_match || (h_cnt_clip == '0);
    status.picked       = chosen_set;
    status.mod_done     = (mod_cnt == '0);
    status.any_eligible = (count != '0) || guard;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) sensors[i] <= '0;
      cur_state <= '0;
    end else begin
      if (cmd.write_sensor && (32'(in_entry) < NUM_SENSORS))
        sensors[SI_W'(in_entry)] <= in_value;
      if (cmd.finish) cur_state <= chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_start) begin
      tr_idx <= '0; c_idx <= '0; count <= '0; seen <= '0;
      sel_pass <= 1'b0; chosen <= cur_state; chosen_set <= 1'b0;
      rem <= in_draw; elig <= '0;
    end
    if (cmd.trans_load) begin
      // hold header; a begin mismatch makes the guard false
      t_to <= h_to; t_en <= h_en && begin_match; t_or <= h_or && begin_match;
      t_cnt <= h_cnt_clip; c_idx <= '0;
      any_c <= 1'b0; all_c <= begin_match;
    end
    if (cmd.cond_eval) begin
      any_c <= any_c | c_true;
      all_c <= all_c & c_true;
      c_idx <= c_idx + 1'b1;
    end
    if (cmd.trans_done) begin
      if (!sel_pass) begin
        elig[tr_idx] <= guard;
        if (guard) count <= count + 1'b1;
      end
    end
    if (cmd.trans_next) begin
      tr_idx <= tr_idx + 1'b1; c_idx <= '0;
    end
    if (cmd.pass2) begin
      tr_idx <= '0; c_idx <= '0; sel_pass <= 1'b1;
    end
    if (sel_pass && cmd.trans_load && !chosen_set && elig[tr_idx]) begin
      if (seen == TC_W'(rem)) begin
        chosen <= h_to; chosen_set <= 1'b1;
      end
      seen <= seen + 1'b1;
    end
    if (cmd.mod_start) begin
      mod_cnt <= ($clog2(DW+1))'(DW);
      quo_bits <= rem; rem <= '0;
    end
    if (cmd.mod_step) begin
      // one restoring step: shift in a dividend bit, subtract count if fits
      logic [DW:0] trial;
      trial = {rem, quo_bits[DW-1]};
      if (trial >= (DW+1)'(count)) rem <= DW'(trial - (DW+1)'(count));
      else rem <= DW'(trial);
      quo_bits <= {quo_bits[DW-2:0], 1'b0};
      mod_cnt <= mod_cnt - 1'b1;
    end
    // output register: holds the result until it is taken
    if (cmd.finish) begin
      new_state      <= chosen;
      eligible_count <= (gts_pkg::CNT_W)'(count);
    end
  end
endmodule

// ===== rtl/core/gts_ctrl.sv =====
// Controller: sequences writes, the guard pass, the modulo and the selection pass.
module gts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  output logic             out_valid,
  input  logic             out_ready,
  output gts_pkg::cmd_t    cmd,
  input  gts_pkg::status_t status
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_HREAD = 8'b00000010,
    S_HLOAD = 8'b00000100,
    S_COND  = 8'b00001000,
    S_DONE  = 8'b00010000,
    S_MODS  = 8'b00100000,
    S_MOD   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic   sel_pass, sel_pass_next;
  logic   out_full, out_full_next;
  logic   acc;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    sel_pass_next = sel_pass;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (gts_pkg::op_t'(in_op))
            gts_pkg::OP_WRITE_SENSOR: cmd.write_sensor = 1'b1;
            gts_pkg::OP_WRITE_HEADER: cmd.write_header = 1'b1;
            gts_pkg::OP_WRITE_COND:   cmd.write_cond = 1'b1;
            gts_pkg::OP_STEP: begin
              cmd.step_start = 1'b1;
              sel_pass_next = 1'b0;
              state_next = S_HREAD;
            end
            default: ;
          endcase
        end
      end
      S_HREAD: begin
        // RAM read latency; an empty table goes straight to commit
        if (status.no_trans) state_next = S_FIN;
        else state_next = S_HLOAD;
      end
      S_HLOAD: begin
        cmd.trans_load = 1'b1;
        if (sel_pass || status.cond_none) state_next = S_DONE;
        else state_next = S_COND;
      end
      S_COND: begin
        cmd.cond_eval = 1'b1;
        if (status.cond_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.trans_done = 1'b1;
        if (status.trans_last || (sel_pass && status.picked)) begin
          if (sel_pass) state_next = S_FIN;
          else if (status.any_eligible) state_next = S_MODS;
          else state_next = S_FIN;
        end else begin
          cmd.trans_next = 1'b1;
          state_next = S_HREAD;
        end
      end
      S_MODS: begin
        cmd.mod_start = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (status.mod_done) begin
          cmd.pass2 = 1'b1;
          sel_pass_next = 1'b1;
          state_next = S_HREAD;
        end else cmd.mod_step = 1'b1;
      end
      S_FIN: begin
        // hold the commit until the output register is free
        if (!out_full || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_full_next = cmd.finish || (out_full && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_pass <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      sel_pass <= sel_pass_next;
      out_full <= out_full_next;
    end
  end
endmodule

// ===== rtl/core/guarded_transition_selector_core.sv =====
// Top level of the guarded transition selector.
// Write transactions (sensor, header, condition slot) are accepted one per cycle while no step
// is in progress and return nothing. A step walks the transitions in use once to count the
// eligible ones: header read, header load and close for each transition, plus one condition
// evaluation per condition of a transition that leaves the current state. If any is eligible,
// a restoring modulo reduces the draw, then a second walk (header read, header load, close)
// stops at the chosen entry, and a final commit state writes the result. The result sits in an
// output register until taken, so writes and the next step go on meanwhile; that step's commit
// holds until the register is free. No clearing pass.
module guarded_transition_selector_core #(
  parameter int NUM_SENSORS          = gts_pkg::NUM_SENSORS_DEF,
  parameter int NUM_TRANSITIONS      = gts_pkg::NUM_TRANSITIONS_DEF,
  parameter int CONDS_PER_TRANSITION = gts_pkg::CONDS_PER_TRANSITION_DEF
) (
  input logic                            clk,
  input logic                            rst,
  gts_if.sink                            in_ch,
  gts_if.source                          out_ch,
  input logic                            cfg_we,
  input logic [gts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [gts_pkg::CFG_W-1:0]       cfg_data
);
  logic [gts_pkg::CNT_W-1:0] sensors_in_use, transitions_in_use;
  logic [gts_pkg::TOL_W-1:0] equal_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensors_in_use     <= gts_pkg::SENSORS_RESET;
      transitions_in_use <= gts_pkg::TRANSITIONS_RESET;
      equal_tolerance    <= gts_pkg::TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gts_pkg::REG_SENSORS_IN_USE:     sensors_in_use <= cfg_data[gts_pkg::CNT_W-1:0];
        gts_pkg::REG_TRANSITIONS_IN_USE: transitions_in_use <= cfg_data[gts_pkg::CNT_W-1:0];
        gts_pkg::REG_EQUAL_TOLERANCE:    equal_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  gts_pkg::cmd_t    cmd;
  gts_pkg::status_t status;

  gts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.data.operation),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .status(status)
  );

  gts_datapath #(
    .NUM_SENSORS(NUM_SENSORS), .NUM_TRANSITIONS(NUM_TRANSITIONS),
    .CONDS_PER_TRANSITION(CONDS_PER_TRANSITION)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_entry(in_ch.data.entry_index),
    .in_slot(in_ch.data.slot_index), .in_value(in_ch.data.sample_value),
    .in_sel(in_ch.data.sensor_select), .in_cmp(in_ch.data.compare_op),
    .in_from(in_ch.data.from_state), .in_to(in_ch.data.to_state),
    .in_enabled(in_ch.data.enabled), .in_use_or(in_ch.data.use_or),
    .in_ccount(in_ch.data.condition_count), .in_draw(in_ch.data.random_draw),
    .sensors_in_use(sensors_in_use), .transitions_in_use(transitions_in_use),
    .equal_tolerance(equal_tolerance),
    .new_state(out_ch.data.new_state), .eligible_count(out_ch.data.eligible_count)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (32'(out_ch.data.eligible_count) <= NUM_TRANSITIONS))
    else $error("eligible count beyond table size");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("stalled result changed");
endmodule

// ===== sim/tb_guarded_transition_selector_core.sv =====
// Testbench for guarded_transition_selector_core: random tables and steps checked by a scoreboard.
module tb_guarded_transition_selector_core;

  localparam logic [gts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 8000;
  localparam int HOLD_CYCLES = 400;

  class selector_scoreboard;
    logic [gts_pkg::CNT_W-1:0] sensors_in_use = gts_pkg::SENSORS_RESET;
    logic [gts_pkg::CNT_W-1:0] transitions_in_use = gts_pkg::TRANSITIONS_RESET;
    logic [gts_pkg::TOL_W-1:0] equal_tolerance = gts_pkg::TOLERANCE_RESET;
    logic [gts_pkg::STATE_W-1:0] cur_state = '0;
    logic signed [gts_pkg::VALUE_W-1:0] sensor_val [16];
    logic [gts_pkg::STATE_W-1:0] hdr_from [16];
    logic [gts_pkg::STATE_W-1:0] hdr_to [16];
    logic hdr_enabled [16];
    logic hdr_use_or [16];
    logic [gts_pkg::CCOUNT_W-1:0] hdr_count [16];
    logic [gts_pkg::SEL_W-1:0] slot_sensor [64];
    gts_pkg::cmp_t slot_cmp [64];
    logic signed [gts_pkg::VALUE_W-1:0] slot_thresh [64];
    gts_pkg::out_item_t expected_q [$];
    int errors = 0;
    int items_in = 0;
    int checked = 0;
    int multi_eligible = 0;

    function new();
      foreach (sensor_val[i]) sensor_val[i] = '0;
    endfunction

    function void configure(logic [gts_pkg::CFG_IDX_W-1:0] idx,
                            logic [gts_pkg::CFG_W-1:0] val);
      case (idx)
        gts_pkg::REG_SENSORS_IN_USE: sensors_in_use = val[gts_pkg::CNT_W-1:0];
        gts_pkg::REG_TRANSITIONS_IN_USE: transitions_in_use = val[gts_pkg::CNT_W-1:0];
        gts_pkg::REG_EQUAL_TOLERANCE: equal_tolerance = val[gts_pkg::TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit condition_true(int s);
      int v, t, d;
      if (slot_sensor[s] >= sensors_in_use || slot_sensor[s] >= 16) return 0;
      v = sensor_val[slot_sensor[s]];
      t = slot_thresh[s];
      d = (v > t) ? v - t : t - v;
      case (slot_cmp[s])
        gts_pkg::CMP_EQUAL: return d < int'(equal_tolerance);
        gts_pkg::CMP_GREATER: return v > t;
        gts_pkg::CMP_LESS: return v < t;
        default: return 0;
      endcase
    endfunction

    function bit guard_true(int tr);
      int n;
      bit any_c, all_c, c;
      n = (hdr_count[tr] > 4) ? 4 : hdr_count[tr];
      any_c = 0;
      all_c = 1;
      for (int k = 0; k < n; k++) begin
        c = condition_true(tr * 4 + k);
        any_c |= c;
        all_c &= c;
      end
      return (hdr_use_or[tr] ? any_c : all_c) && hdr_enabled[tr];
    endfunction

    function void note_input(gts_pkg::in_item_t it);
      int limit, count, pick, seen;
      int slot;
      gts_pkg::out_item_t r;
      items_in++;
      case (it.operation)
        gts_pkg::OP_WRITE_SENSOR: sensor_val[it.entry_index] = it.sample_value;
        gts_pkg::OP_WRITE_HEADER: begin
          hdr_from[it.entry_index] = it.from_state;
          hdr_to[it.entry_index] = it.to_state;
          hdr_enabled[it.entry_index] = it.enabled;
          hdr_use_or[it.entry_index] = it.use_or;
          hdr_count[it.entry_index] = it.condition_count;
        end
        gts_pkg::OP_WRITE_COND: begin
          slot = it.entry_index * 4 + it.slot_index;
          slot_sensor[slot] = it.sensor_select;
          slot_cmp[slot] = it.compare_op;
          slot_thresh[slot] = it.sample_value;
        end
        default: begin
          limit = (transitions_in_use > 16) ? 16 : transitions_in_use;
          count = 0;
          for (int tr = 0; tr < limit; tr++)
            if (hdr_from[tr] == cur_state && guard_true(tr)) count++;
          if (count > 0) begin
            pick = it.random_draw % count;
            seen = 0;
            for (int tr = 0; tr < limit; tr++)
              if (hdr_from[tr] == cur_state && guard_true(tr)) begin
                if (seen == pick) begin
                  cur_state = hdr_to[tr];
                  break;
                end
                seen++;
              end
          end
          if (count > 1) multi_eligible++;
          r.new_state = cur_state;
          r.eligible_count = count[gts_pkg::CNT_W-1:0];
          expected_q.push_back(r);
        end
      endcase
    endfunction

    function void check_result(gts_pkg::out_item_t got);
      gts_pkg::out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no step outstanding: new_state %0d", got.new_state);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.new_state !== exp_r.new_state) begin
        $error("new_state: expected %0d, got %0d", exp_r.new_state, got.new_state);
        errors++;
      end
      if (got.eligible_count !== exp_r.eligible_count) begin
        $error("eligible_count: expected %0d, got %0d", exp_r.eligible_count,
               got.eligible_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [gts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gts_pkg::CFG_W-1:0] cfg_data = '0;

  gts_if #(.payload_t(gts_pkg::in_item_t)) in_ch ();
  gts_if #(.payload_t(gts_pkg::out_item_t)) out_ch ();

  guarded_transition_selector_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  selector_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(gts_pkg::in_item_t it);
    if (send_idle_pct > 0)
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_ch.valid <= 0;
        @(posedge clk);
      end
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [gts_pkg::CFG_IDX_W-1:0] idx, logic [gts_pkg::CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.configure(idx, val);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [gts_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return (gts_pkg::VALUE_W)'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 80))) - 16'sd40;
    endcase
  endfunction

  function automatic gts_pkg::in_item_t random_item();
    gts_pkg::in_item_t it;
    int w;
    it = gts_pkg::in_item_t'(($bits(gts_pkg::in_item_t))'({$urandom, $urandom}));
    w = $urandom_range(0, 99);
    it.operation = (w < 50) ? gts_pkg::OP_STEP : (w < 70) ? gts_pkg::OP_WRITE_SENSOR :
                   (w < 85) ? gts_pkg::OP_WRITE_HEADER : gts_pkg::OP_WRITE_COND;
    it.sample_value = pick_value();
    if ($urandom_range(0, 9) != 0) begin
      // keep the graph small so steps keep finding live transitions
      it.from_state = (gts_pkg::STATE_W)'($urandom_range(0, 3));
      it.to_state = (gts_pkg::STATE_W)'($urandom_range(0, 3));
      it.sensor_select = (gts_pkg::SEL_W)'($urandom_range(0, 15));
      it.enabled = ($urandom_range(0, 9) != 0);
      it.condition_count = (gts_pkg::CCOUNT_W)'($urandom_range(0, 4));
    end
    return it;
  endfunction

  function automatic gts_pkg::in_item_t header_item(int e, int b, int n, int cnt, bit orm);
    gts_pkg::in_item_t it;
    it = '0;
    it.operation = gts_pkg::OP_WRITE_HEADER;
    it.entry_index = (gts_pkg::ENTRY_W)'(e);
    it.from_state = (gts_pkg::STATE_W)'(b);
    it.to_state = (gts_pkg::STATE_W)'(n);
    it.enabled = 1;
    it.use_or = orm;
    it.condition_count = (gts_pkg::CCOUNT_W)'(cnt);
    return it;
  endfunction

  function automatic gts_pkg::in_item_t cond_item(int e, int s, int sel, gts_pkg::cmp_t c,
                                                  int thr);
    gts_pkg::in_item_t it;
    it = '0;
    it.operation = gts_pkg::OP_WRITE_COND;
    it.entry_index = (gts_pkg::ENTRY_W)'(e);
    it.slot_index = (gts_pkg::SLOT_W)'(s);
    it.sensor_select = (gts_pkg::SEL_W)'(sel);
    it.compare_op = c;
    it.sample_value = (gts_pkg::VALUE_W)'(thr);
    return it;
  endfunction

  function automatic gts_pkg::in_item_t sensor_item(int e, int v);
    gts_pkg::in_item_t it;
    it = '0;
    it.operation = gts_pkg::OP_WRITE_SENSOR;
    it.entry_index = (gts_pkg::ENTRY_W)'(e);
    it.sample_value = (gts_pkg::VALUE_W)'(v);
    return it;
  endfunction

  function automatic gts_pkg::in_item_t step_item(int draw);
    gts_pkg::in_item_t it;
    it = '0;
    it.operation = gts_pkg::OP_STEP;
    it.random_draw = (gts_pkg::DRAW_W)'(draw);
    return it;
  endfunction

  initial begin
    int sens_cfg [8] = '{16, 0, 5, 31, 16, 8, 16, 1};
    int trans_cfg [8] = '{16, 16, 8, 31, 16, 0, 4, 16};
    int tol_cfg [8] = '{20, 0, 32767, 100, 1, 20, 5000, 20};
    gts_pkg::in_item_t it;

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // nothing in use after reset: state must hold
    send(step_item(16'hFFFF));
    // fill every header and condition slot so no step reads an unwritten entry
    for (int e = 0; e < 16; e++) begin
      it = random_item();
      it.operation = gts_pkg::OP_WRITE_HEADER;
      it.entry_index = (gts_pkg::ENTRY_W)'(e);
      send(it);
      for (int s = 0; s < 4; s++) begin
        it = random_item();
        it.operation = gts_pkg::OP_WRITE_COND;
        it.entry_index = (gts_pkg::ENTRY_W)'(e);
        it.slot_index = (gts_pkg::SLOT_W)'(s);
        send(it);
      end
    end
    drain();

    // directed: tolerance edge, extremes, empty lists, out-of-range sensor, bad op
    write_reg(gts_pkg::REG_SENSORS_IN_USE, 15'd16);
    write_reg(gts_pkg::REG_TRANSITIONS_IN_USE, 15'd4);
    write_reg(gts_pkg::REG_EQUAL_TOLERANCE, 15'd20);
    write_reg(REG_UNUSED, 15'h7FFF);
    send(sensor_item(0, 100));
    send(sensor_item(1, 32767));
    send(sensor_item(15, -32768));
    send(header_item(0, 0, 1, 1, 0));
    send(cond_item(0, 0, 0, gts_pkg::CMP_EQUAL, 120));     // diff equals tolerance: false
    send(header_item(1, 0, 2, 0, 1));                      // empty OR: false
    send(header_item(2, 0, 3, 2, 0));
    send(cond_item(2, 0, 1, gts_pkg::CMP_GREATER, 32766));
    send(cond_item(2, 1, 15, gts_pkg::CMP_LESS, -32767));
    send(header_item(3, 0, 5, 7, 1));                      // count clipped to four
    send(cond_item(3, 0, 20, gts_pkg::CMP_EQUAL, 100));    // sensor beyond range
    send(cond_item(3, 1, 0, gts_pkg::CMP_INVALID, 100));
    send(cond_item(3, 2, 16, gts_pkg::CMP_GREATER, -32768));
    send(cond_item(3, 3, 0, gts_pkg::CMP_EQUAL, 119));     // diff below tolerance: true
    send(step_item(1));
    send(cond_item(0, 0, 0, gts_pkg::CMP_EQUAL, 119));
    send(header_item(1, 3, 0, 0, 0));                      // empty AND: true
    send(step_item(0));
    send(step_item(65535));
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(gts_pkg::REG_SENSORS_IN_USE, (gts_pkg::CFG_W)'(sens_cfg[p]));
      write_reg(gts_pkg::REG_TRANSITIONS_IN_USE, (gts_pkg::CFG_W)'(trans_cfg[p]));
      write_reg(gts_pkg::REG_EQUAL_TOLERANCE, (gts_pkg::CFG_W)'(tol_cfg[p]));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (p == 4) hold_req = 1;
      for (int i = 0; i < 90; i++) send(random_item());
      drain();
    end

    $display("Ran %0d input transactions, checked %0d step results (%0d with several eligible)",
             sb.items_in, sb.checked, sb.multi_eligible);
    $display("over 8 register settings with sender/receiver idling and one long output hold-off");
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
